// File: hdl/rsrb_pkg.sv
// rsrb_pkg: shared types and constants of the rtp sequence reorder buffer
// used by every module under hdl; no dependencies
package rsrb_pkg;

  localparam int DEF_LOSS_LIMIT  = 15000;
  localparam int DEF_SLOT_COUNT  = 16384;
  localparam int DEF_HANDLE_BITS = 16;

  localparam int MS_PER_S = 1000;

  localparam logic [7:0] RST_MAX_HELD    = 8'd5;
  localparam logic [7:0] RST_MAX_WAIT    = 8'd1;
  localparam logic [7:0] RST_MAX_SILENCE = 8'd10;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_FLUSHED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_POPPED  = 3'd3,
    ST_NONE    = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_MAX_HELD    = 2'd0,
    REG_MAX_WAIT    = 2'd1,
    REG_MAX_SILENCE = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_MODW,
    S_DECIDE,
    S_RESTART,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage

// File: hdl/rsrb_slot_mod.sv
// rsrb_slot_mod: remainder of a sequence number by the slot count
// reciprocal multiply for the registered quotient, then multiply and subtract into the registered slot; uses rsrb_pkg
module rsrb_slot_mod #(
  parameter int SLOT_COUNT = rsrb_pkg::DEF_SLOT_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [15:0]                   value,
  output logic                          done,
  output logic [$clog2(SLOT_COUNT)-1:0] slot
);
  import rsrb_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int SH = 16 + SW;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SH) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT);
  localparam logic [16:0] RECIP   = 17'(RECIP_FULL);
  localparam logic [16:0] DIVISOR = 17'(SLOT_COUNT);

  logic [32:0] prod;
  logic [15:0] q;
  logic [15:0] val_r;
  logic [31:0] back_prod;
  logic [15:0] rem;
  logic        busy;

  assign prod      = 33'(value) * 33'(RECIP);
  assign back_prod = 32'(q) * 32'(DIVISOR);
  assign rem       = val_r - back_prod[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
      if (start) begin
        q     <= 16'(prod >> SH);
        val_r <= value;
      end
      if (busy) begin
        slot <= SW'(rem);
      end
    end
  end

endmodule

// File: hdl/rsrb_store.sv
// rsrb_store: occupancy and slot data memories, one write and one read port
// read data registered; uses rsrb_pkg
module rsrb_store #(
  parameter int SLOT_COUNT = rsrb_pkg::DEF_SLOT_COUNT,
  parameter int HS         = rsrb_pkg::DEF_HANDLE_BITS
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  output logic                          rd_occ,
  output logic [HS-1:0]                 rd_handle,
  output logic [31:0]                   rd_time,
  input  logic                          wr_occ_en,
  input  logic                          wr_data_en,
  input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
  input  logic                          wr_occ,
  input  logic [HS-1:0]                 wr_handle,
  input  logic [31:0]                   wr_time
);
  import rsrb_pkg::*;

  logic          occ_mem  [SLOT_COUNT];
  logic [HS+31:0] data_mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr_occ_en) begin
      occ_mem[wr_addr] <= wr_occ;
    end
    if (rd_en) begin
      rd_occ <= occ_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_data_en) begin
      data_mem[wr_addr] <= {wr_handle, wr_time};
    end
    if (rd_en) begin
      {rd_handle, rd_time} <= data_mem[rd_addr];
    end
  end

endmodule

// File: hdl/rtp_sequence_reorder_buffer_unit.sv
// rtp_sequence_reorder_buffer_unit: top level, sequencer and registers
// instantiates rsrb_slot_mod and rsrb_store; uses rsrb_pkg
//
//  channel  handshake            payload
//  in       in_valid / in_stall  mode, seq_number, packet_handle, now_ms
//  out      out_valid/ out_stall status, out_handle, out_seq, flushed_count
//  cfg      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// push: slot remainder, one memory read and, when the slot is free, one write; no read or write when dropped
// outside the window
// pop: a search over the slots from the expected slot, stopping at the first occupied one
// clear and flush: a pass over all occupancy entries, one a cycle; the same pass runs after reset
// one item at a time; in_stall is high outside the idle state, a held result adds its stall
module rtp_sequence_reorder_buffer_unit #(
  parameter int LOSS_LIMIT  = rsrb_pkg::DEF_LOSS_LIMIT,
  parameter int SLOT_COUNT  = rsrb_pkg::DEF_SLOT_COUNT,
  parameter int HANDLE_BITS = rsrb_pkg::DEF_HANDLE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] seq_number,
  input  logic [15:0] packet_handle,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] out_handle,
  output logic [15:0] out_seq,
  output logic [14:0] flushed_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import rsrb_pkg::*;

  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int CW  = $clog2(SLOT_COUNT + 1);
  localparam int WIN = (LOSS_LIMIT < SLOT_COUNT) ? LOSS_LIMIT : SLOT_COUNT;
  localparam int HS  = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
  localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

  state_t state, state_next;

  logic          clr_boot, clr_restart;
  logic [SW-1:0] clr_ptr;
  logic [15:0]   m_seq;
  logic [HS-1:0] m_handle;
  logic [31:0]   m_now;
  logic          started;
  logic [15:0]   exp_seq;
  logic [SW-1:0] exp_slot;
  logic [31:0]   lvt;
  logic [CW-1:0] count;
  logic [7:0]    max_held, max_wait, max_silence;
  logic [SW-1:0] slot_k;
  logic [SW-1:0] scan_i, scan_k, k_adv;
  logic [15:0]   scan_s;
  status_t       res_status;
  logic [15:0]   res_handle, res_seq;
  logic [14:0]   res_flushed;

  // mod unit reads the latched sequence, so its start is registered and comes in the cycle after the beat
  logic          mod_go;
  logic          mod_start, mod_done;
  logic [SW-1:0] mod_slot;
  logic          rd_en, rd_occ, wr_occ_en, wr_data_en, wr_occ;
  logic [SW-1:0] rd_addr, wr_addr;
  logic [HS-1:0] rd_handle;
  logic [31:0]   rd_time;

  logic [15:0]   eff_exp, d, back;
  logic [31:0]   eff_lvt, sil_ms, wait_ms;
  logic          silence, in_win, small_back, restart_c, pop_ready, out_free;

  rsrb_slot_mod #(.SLOT_COUNT(SLOT_COUNT)) u_mod (
    .clk(clk), .rst(rst), .start(mod_go), .value(m_seq),
    .done(mod_done), .slot(mod_slot)
  );

  rsrb_store #(.SLOT_COUNT(SLOT_COUNT), .HS(HS)) u_store (
    .clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_occ(rd_occ),
    .rd_handle(rd_handle), .rd_time(rd_time), .wr_occ_en(wr_occ_en),
    .wr_data_en(wr_data_en), .wr_addr(wr_addr), .wr_occ(wr_occ),
    .wr_handle(m_handle), .wr_time(m_now)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign eff_exp    = started ? exp_seq : m_seq;
  assign eff_lvt    = started ? lvt : m_now;
  assign sil_ms     = 32'(max_silence) * 32'(MS_PER_S);
  assign wait_ms    = 32'(max_wait) * 32'(MS_PER_S);
  assign silence    = (m_now - eff_lvt) > sil_ms;
  assign d          = m_seq - eff_exp;
  assign back       = 16'd0 - d;
  assign in_win     = {1'b0, d} < 17'(WIN);
  assign small_back = (back != 16'd0) && ({1'b0, back} < 17'(LOSS_LIMIT));
  assign restart_c  = silence || (!in_win && !small_back);
  assign pop_ready  = (scan_i == '0) || (32'(count) >= 32'(max_held)) ||
                      ((m_now - rd_time) >= wait_ms);
  assign k_adv      = (scan_s == 16'hFFFF) ? '0 :
                      (scan_k == LAST) ? '0 : scan_k + 1'b1;

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = exp_slot;
    wr_occ_en  = 1'b0;
    wr_data_en = 1'b0;
    wr_addr    = slot_k;
    wr_occ     = 1'b0;
    mod_start  = 1'b0;
    case (state)
      S_CLR: begin
        wr_occ_en = 1'b1;
        wr_addr   = clr_ptr;
        if (clr_ptr == LAST) begin
          state_next = clr_boot ? S_IDLE : (clr_restart ? S_RESTART : S_EMIT);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (mode_t'(mode))
            MODE_PUSH: begin
              state_next = S_MODW;
            end
            MODE_POP: begin
              if (count == '0) begin
                state_next = S_EMIT;
              end else begin
                rd_en      = 1'b1;
                state_next = S_SCAN;
              end
            end
            MODE_CLEAR: state_next = S_CLR;
            default:    state_next = S_EMIT;
          endcase
        end
      end
      S_MODW: begin
        if (mod_done) begin
          if (restart_c) begin
            state_next = S_CLR;
          end else if (in_win) begin
            rd_en      = 1'b1;
            rd_addr    = mod_slot;
            state_next = S_DECIDE;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_DECIDE: begin
        if (!rd_occ) begin
          wr_occ_en  = 1'b1;
          wr_data_en = 1'b1;
          wr_occ     = 1'b1;
        end
        state_next = S_EMIT;
      end
      S_RESTART: begin
        wr_occ_en  = 1'b1;
        wr_data_en = 1'b1;
        wr_occ     = 1'b1;
        state_next = S_EMIT;
      end
      S_SCAN: begin
        if (rd_occ) begin
          if (pop_ready) begin
            wr_occ_en = 1'b1;
            wr_addr   = scan_k;
          end
          state_next = S_EMIT;
        end else if (scan_i == LAST) begin
          state_next = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = k_adv;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_IDLE && in_valid && mode_t'(mode) == MODE_PUSH) begin
      mod_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_boot    <= 1'b1;
      clr_restart <= 1'b0;
      clr_ptr     <= '0;
      started     <= 1'b0;
      exp_seq     <= '0;
      exp_slot    <= '0;
      lvt         <= '0;
      count       <= '0;
      max_held    <= RST_MAX_HELD;
      max_wait    <= RST_MAX_WAIT;
      max_silence <= RST_MAX_SILENCE;
      out_valid   <= 1'b0;
      mod_go      <= 1'b0;
    end else begin
      state  <= state_next;
      mod_go <= mod_start;
      if (cfg_valid && cfg_data != 8'd0) begin
        case (reg_idx_t'(cfg_index))
          REG_MAX_HELD:    max_held    <= cfg_data;
          REG_MAX_WAIT:    max_wait    <= cfg_data;
          REG_MAX_SILENCE: max_silence <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_ptr <= (clr_ptr == LAST) ? '0 : clr_ptr + 1'b1;
          if (clr_ptr == LAST) begin
            clr_boot <= 1'b0;
            if (!clr_boot && !clr_restart) begin
              started  <= 1'b0;
              exp_seq  <= '0;
              exp_slot <= '0;
              lvt      <= '0;
            end
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            m_seq       <= seq_number;
            m_handle    <= HS'(packet_handle);
            m_now       <= now_ms;
            scan_i      <= '0;
            scan_s      <= exp_seq;
            scan_k      <= exp_slot;
            res_handle  <= '0;
            res_seq     <= '0;
            if (mode_t'(mode) == MODE_CLEAR) begin
              res_status  <= ST_CLEARED;
              res_flushed <= 15'(count);
              count       <= '0;
              clr_restart <= 1'b0;
              clr_ptr     <= '0;
            end else begin
              res_status  <= ST_NONE;
              res_flushed <= '0;
            end
          end
        end
        S_MODW: begin
          if (mod_done) begin
            slot_k <= mod_slot;
            if (!started) begin
              started  <= 1'b1;
              exp_seq  <= m_seq;
              exp_slot <= mod_slot;
              lvt      <= m_now;
            end
            if (restart_c) begin
              clr_restart <= 1'b1;
              clr_ptr     <= '0;
              res_status  <= ST_FLUSHED;
              res_flushed <= 15'(count);
              count       <= '0;
            end else if (!in_win) begin
              res_status <= ST_DROPPED;
            end
          end
        end
        S_DECIDE: begin
          if (rd_occ) begin
            res_status <= ST_DROPPED;
          end else begin
            res_status <= ST_STORED;
            count      <= count + 1'b1;
            lvt        <= m_now;
          end
        end
        S_RESTART: begin
          count    <= CW'(1);
          exp_seq  <= m_seq;
          exp_slot <= slot_k;
          lvt      <= m_now;
        end
        S_SCAN: begin
          if (rd_occ) begin
            if (pop_ready) begin
              res_status <= ST_POPPED;
              res_handle <= 16'(rd_handle);
              res_seq    <= scan_s;
              count      <= count - 1'b1;
              exp_seq    <= scan_s + 16'd1;
              exp_slot   <= k_adv;
            end
          end else begin
            scan_i <= scan_i + 1'b1;
            scan_s <= scan_s + 16'd1;
            scan_k <= k_adv;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            out_handle    <= res_handle;
            out_seq       <= res_seq;
            flushed_count <= res_flushed;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
